FILE: rtl/core/ccdst_pkg.sv
package ccdst_pkg;

  typedef enum logic [1:0] {
    MODE_ADV  = 2'd0,
    MODE_REW  = 2'd1,
    MODE_LOAD = 2'd2,
    MODE_KEEP = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_TAKE,
    CMD_STEP,
    CMD_WALK,
    CMD_MULY,
    CMD_YMOD,
    CMD_LDAY,
    CMD_WPREP,
    CMD_MULW,
    CMD_WSUM,
    CMD_MUL7,
    CMD_FINISH
  } cmd_t;

  localparam logic [1:0] DST_NONE   = 2'd0;
  localparam logic [1:0] DST_SPRING = 2'd1;
  localparam logic [1:0] DST_FALL   = 2'd2;

  localparam logic [9:0] MSEC_MAX  = 10'd999;
  localparam logic [5:0] SEC_MAX   = 6'd59;
  localparam logic [5:0] MIN_MAX   = 6'd59;
  localparam logic [4:0] HOUR_MAX  = 5'd23;
  localparam logic [3:0] MONTH_MAX = 4'd11;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_MAR = 4'd2;
  localparam logic [3:0] MONTH_OCT = 4'd9;

  localparam logic [13:0] YEAR_RESET  = 14'd2014;
  localparam logic [6:0]  YMOD_RESET  = 7'd14;
  localparam logic [1:0]  YCENT_RESET = 2'd0;
  localparam logic [13:0] YEAR_TOP    = 14'd16383;
  localparam logic [6:0]  YMOD_TOP    = 7'd83;
  localparam logic [1:0]  YCENT_TOP   = 2'd3;

  // floor(x/100) = (x*5243) >> 19 for x < 32768
  localparam logic [12:0] RECIP100    = 13'd5243;
  // floor(x/7) = (x*37450) >> 18 for x < 32768
  localparam logic [15:0] RECIP7      = 16'd37450;

  localparam logic [4:0] DST_DAY_MIN  = 5'd24;
  localparam logic [4:0] DST_HOUR_MIN = 5'd2;
  localparam logic [2:0] SUNDAY       = 3'd6;

  function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
    logic [4:0] n;
    unique case (month) inside
      4'd1:                      n = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  // floor(23*m/9) for one-based month m
  function automatic logic [4:0] month_term(input logic [3:0] month);
    logic [4:0] t;
    unique case (month)
      4'd0:    t = 5'd2;
      4'd1:    t = 5'd5;
      4'd2:    t = 5'd7;
      4'd3:    t = 5'd10;
      4'd4:    t = 5'd12;
      4'd5:    t = 5'd15;
      4'd6:    t = 5'd17;
      4'd7:    t = 5'd20;
      4'd8:    t = 5'd23;
      4'd9:    t = 5'd25;
      4'd10:   t = 5'd28;
      default: t = 5'd30;
    endcase
    return t;
  endfunction

endpackage

FILE: rtl/core/ccdst_ctrl.sv
module ccdst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_mode,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  logic              walk_done,
  output ccdst_pkg::cmd_t   cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_STEP,
    S_WALK,
    S_LQ,
    S_LMOD,
    S_LDAY,
    S_WY,
    S_WQ,
    S_WSUM,
    S_WQ7,
    S_WOUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = ccdst_pkg::CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd = ccdst_pkg::CMD_TAKE;
          unique case (ccdst_pkg::mode_t'(in_mode)) inside
            ccdst_pkg::MODE_ADV,
            ccdst_pkg::MODE_REW:  state_nxt = S_STEP;
            ccdst_pkg::MODE_LOAD: state_nxt = S_LQ;
            default:              state_nxt = S_WY;
          endcase
        end
      end
      S_STEP: begin
        cmd       = ccdst_pkg::CMD_STEP;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd = ccdst_pkg::CMD_WALK;
        if (walk_done) begin
          state_nxt = S_WY;
        end
      end
      S_LQ: begin
        cmd       = ccdst_pkg::CMD_MULY;
        state_nxt = S_LMOD;
      end
      S_LMOD: begin
        cmd       = ccdst_pkg::CMD_YMOD;
        state_nxt = S_LDAY;
      end
      S_LDAY: begin
        cmd       = ccdst_pkg::CMD_LDAY;
        state_nxt = S_WY;
      end
      S_WY: begin
        cmd       = ccdst_pkg::CMD_WPREP;
        state_nxt = S_WQ;
      end
      S_WQ: begin
        cmd       = ccdst_pkg::CMD_MULW;
        state_nxt = S_WSUM;
      end
      S_WSUM: begin
        cmd       = ccdst_pkg::CMD_WSUM;
        state_nxt = S_WQ7;
      end
      S_WQ7: begin
        cmd       = ccdst_pkg::CMD_MUL7;
        state_nxt = S_WOUT;
      end
      S_WOUT: begin
        if (!out_valid_r || out_ready) begin
          cmd           = ccdst_pkg::CMD_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/ccdst_dp.sv
module ccdst_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ccdst_pkg::cmd_t   cmd,
  input  logic [1:0]        in_mode,
  input  logic [9:0]        in_msec_val,
  input  logic [5:0]        in_sec_val,
  input  logic [5:0]        in_min_val,
  input  logic [4:0]        in_hour_val,
  input  logic [9:0]        in_day_val,
  input  logic [3:0]        in_month_val,
  input  logic [13:0]       in_year_val,
  output logic              walk_done,
  output logic [13:0]       out_year_out,
  output logic [3:0]        out_month_out,
  output logic [4:0]        out_day_out,
  output logic [4:0]        out_hour_out,
  output logic [5:0]        out_minute_out,
  output logic [5:0]        out_second_out,
  output logic [9:0]        out_msec_out,
  output logic [2:0]        out_weekday_out,
  output logic [1:0]        out_dst_event
);

  // calendar state
  logic [13:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  min_r;
  logic [5:0]  sec_r;
  logic [9:0]  msec_r;
  logic [6:0]  ymod_r;
  logic [1:0]  ycent_r;
  logic        summer_r;
  logic        winter_r;

  // work registers
  logic [1:0]  mode_r;
  logic [9:0]  sp_ms_r;
  logic [5:0]  sp_s_r;
  logic [5:0]  sp_mi_r;
  logic [4:0]  sp_h_r;
  logic [9:0]  dv_r;
  logic [11:0] day_w_r;
  logic [7:0]  mq_r;
  logic [14:0] wy_r;
  logic [14:0] wd_r;
  logic [14:0] ws_r;
  logic [11:0] q7_r;

  logic [9:0]  sat_ms;
  logic [5:0]  sat_s;
  logic [5:0]  sat_mi;
  logic [4:0]  sat_h;
  logic [3:0]  sat_mo;

  assign sat_ms = (in_msec_val > ccdst_pkg::MSEC_MAX) ? ccdst_pkg::MSEC_MAX : in_msec_val;
  assign sat_s  = (in_sec_val  > ccdst_pkg::SEC_MAX)  ? ccdst_pkg::SEC_MAX  : in_sec_val;
  assign sat_mi = (in_min_val  > ccdst_pkg::MIN_MAX)  ? ccdst_pkg::MIN_MAX  : in_min_val;
  assign sat_h  = (in_hour_val > ccdst_pkg::HOUR_MAX) ? ccdst_pkg::HOUR_MAX : in_hour_val;
  assign sat_mo = (in_month_val > ccdst_pkg::MONTH_MAX) ? ccdst_pkg::MONTH_MAX : in_month_val;

  logic is_rew;
  assign is_rew = (mode_r == ccdst_pkg::MODE_REW);

  // advance: add with one carry per field
  logic [10:0] a_ms;
  logic [6:0]  a_s, a_mi;
  logic [5:0]  a_h;
  logic        c0, c1, c2, c3;
  logic [9:0]  a_ms_n;
  logic [5:0]  a_s_n, a_mi_n;
  logic [4:0]  a_h_n;
  logic [11:0] a_day;

  always_comb begin
    a_ms   = {1'b0, msec_r} + {1'b0, sp_ms_r};
    c0     = (a_ms >= 11'd1000);
    a_ms_n = c0 ? 10'(a_ms - 11'd1000) : a_ms[9:0];
    a_s    = {1'b0, sec_r} + {6'd0, c0} + {1'b0, sp_s_r};
    c1     = (a_s >= 7'd60);
    a_s_n  = c1 ? 6'(a_s - 7'd60) : a_s[5:0];
    a_mi   = {1'b0, min_r} + {6'd0, c1} + {1'b0, sp_mi_r};
    c2     = (a_mi >= 7'd60);
    a_mi_n = c2 ? 6'(a_mi - 7'd60) : a_mi[5:0];
    a_h    = {1'b0, hour_r} + {5'd0, c2} + {1'b0, sp_h_r};
    c3     = (a_h >= 6'd24);
    a_h_n  = c3 ? 5'(a_h - 6'd24) : a_h[4:0];
    a_day  = {7'd0, day_r} + {11'd0, c3} + {2'd0, dv_r};
  end

  // rewind: subtract with one borrow per field
  logic        b0, b1, b2, b3;
  logic [6:0]  r_st, r_mt;
  logic [5:0]  r_ht;
  logic [9:0]  r_ms_n;
  logic [5:0]  r_s_n, r_mi_n;
  logic [4:0]  r_h_n;
  logic [11:0] r_day;

  always_comb begin
    b0     = (msec_r < sp_ms_r);
    r_ms_n = b0 ? 10'({1'b0, msec_r} + 11'd1000 - {1'b0, sp_ms_r})
                : 10'(msec_r - sp_ms_r);
    r_st   = {1'b0, sp_s_r} + {6'd0, b0};
    b1     = ({1'b0, sec_r} < r_st);
    r_s_n  = b1 ? 6'({1'b0, sec_r} + 7'd60 - r_st) : 6'({1'b0, sec_r} - r_st);
    r_mt   = {1'b0, sp_mi_r} + {6'd0, b1};
    b2     = ({1'b0, min_r} < r_mt);
    r_mi_n = b2 ? 6'({1'b0, min_r} + 7'd60 - r_mt) : 6'({1'b0, min_r} - r_mt);
    r_ht   = {1'b0, sp_h_r} + {5'd0, b2};
    b3     = ({1'b0, hour_r} < r_ht);
    r_h_n  = b3 ? 5'({1'b0, hour_r} + 6'd24 - r_ht) : 5'({1'b0, hour_r} - r_ht);
    r_day  = {7'd0, day_r} - {11'd0, b3} - {2'd0, dv_r};
  end

  // month walk
  logic        leap;
  logic [3:0]  prev_month;
  logic [3:0]  wk_month;
  logic [4:0]  wk_len;
  logic [13:0] yinc, ydec;
  logic [6:0]  minc, mdec;
  logic [1:0]  cinc, cdec;

  always_comb begin
    leap       = (year_r[1:0] == 2'd0) && ((ymod_r != 7'd0) || (ycent_r == 2'd0));
    prev_month = (month_r == 4'd0) ? ccdst_pkg::MONTH_MAX : 4'(month_r - 4'd1);
    wk_month   = is_rew ? prev_month : month_r;
    wk_len     = ccdst_pkg::days_in(wk_month, leap);
    walk_done  = is_rew ? !day_w_r[11] : (day_w_r < {7'd0, wk_len});

    if (year_r == ccdst_pkg::YEAR_TOP) begin
      yinc = 14'd0;
      minc = 7'd0;
      cinc = 2'd0;
    end else begin
      yinc = 14'(year_r + 14'd1);
      minc = (ymod_r == 7'd99) ? 7'd0 : 7'(ymod_r + 7'd1);
      cinc = (ymod_r == 7'd99) ? 2'(ycent_r + 2'd1) : ycent_r;
    end
    if (year_r == 14'd0) begin
      ydec = ccdst_pkg::YEAR_TOP;
      mdec = ccdst_pkg::YMOD_TOP;
      cdec = ccdst_pkg::YCENT_TOP;
    end else begin
      ydec = 14'(year_r - 14'd1);
      mdec = (ymod_r == 7'd0) ? 7'd99 : 7'(ymod_r - 7'd1);
      cdec = (ymod_r == 7'd0) ? 2'(ycent_r - 2'd1) : ycent_r;
    end
  end

  // shared divide-by-100 multiplier
  logic [14:0] mul_a;
  logic [27:0] prod100;
  logic [30:0] prod7;
  logic [13:0] ymod_full;

  assign mul_a     = (cmd == ccdst_pkg::CMD_MULY) ? {1'b0, year_r} : wy_r;
  assign prod100   = 28'(mul_a) * 28'(ccdst_pkg::RECIP100);
  assign prod7     = 31'(ws_r) * 31'(ccdst_pkg::RECIP7);
  assign ymod_full = year_r - ({6'd0, mq_r} * 14'd100);

  logic [4:0]  ld_max;
  logic [14:0] w_rem;
  logic [2:0]  wday;
  logic        dst_ok;
  logic        fire_spring, fire_fall;

  always_comb begin
    ld_max      = 5'(ccdst_pkg::days_in(month_r, leap) - 5'd1);
    w_rem       = ws_r - ({3'd0, q7_r} * 15'd7);
    wday        = w_rem[2:0];
    dst_ok      = (day_r >= ccdst_pkg::DST_DAY_MIN) && (hour_r >= ccdst_pkg::DST_HOUR_MIN)
                  && (wday == ccdst_pkg::SUNDAY);
    fire_spring = dst_ok && (month_r == ccdst_pkg::MONTH_MAR) && !summer_r;
    fire_fall   = dst_ok && !fire_spring && (month_r == ccdst_pkg::MONTH_OCT) && !winter_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r   <= ccdst_pkg::YEAR_RESET;
      month_r  <= 4'd0;
      day_r    <= 5'd0;
      hour_r   <= 5'd0;
      min_r    <= 6'd0;
      sec_r    <= 6'd0;
      msec_r   <= 10'd0;
      ymod_r   <= ccdst_pkg::YMOD_RESET;
      ycent_r  <= ccdst_pkg::YCENT_RESET;
      summer_r <= 1'b0;
      winter_r <= 1'b0;
    end else begin
      unique case (cmd)
        ccdst_pkg::CMD_TAKE: begin
          if (in_mode == ccdst_pkg::MODE_LOAD) begin
            year_r  <= in_year_val;
            month_r <= sat_mo;
            hour_r  <= sat_h;
            min_r   <= sat_mi;
            sec_r   <= sat_s;
            msec_r  <= sat_ms;
          end
        end
        ccdst_pkg::CMD_STEP: begin
          msec_r <= is_rew ? r_ms_n : a_ms_n;
          sec_r  <= is_rew ? r_s_n  : a_s_n;
          min_r  <= is_rew ? r_mi_n : a_mi_n;
          hour_r <= is_rew ? r_h_n  : a_h_n;
        end
        ccdst_pkg::CMD_WALK: begin
          if (walk_done) begin
            day_r <= day_w_r[4:0];
          end else if (is_rew) begin
            month_r <= prev_month;
            if (month_r == 4'd0) begin
              year_r  <= ydec;
              ymod_r  <= mdec;
              ycent_r <= cdec;
            end
          end else begin
            if (month_r == ccdst_pkg::MONTH_MAX) begin
              month_r <= 4'd0;
              year_r  <= yinc;
              ymod_r  <= minc;
              ycent_r <= cinc;
            end else begin
              month_r <= 4'(month_r + 4'd1);
            end
          end
        end
        ccdst_pkg::CMD_YMOD: begin
          ymod_r  <= ymod_full[6:0];
          ycent_r <= mq_r[1:0];
        end
        ccdst_pkg::CMD_LDAY: begin
          day_r <= ({5'd0, ld_max} < dv_r) ? ld_max : dv_r[4:0];
        end
        ccdst_pkg::CMD_FINISH: begin
          if (fire_spring) begin
            summer_r <= 1'b1;
            winter_r <= 1'b0;
          end else if (fire_fall) begin
            winter_r <= 1'b1;
            summer_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd) inside
      ccdst_pkg::CMD_TAKE: begin
        mode_r  <= in_mode;
        sp_ms_r <= sat_ms;
        sp_s_r  <= sat_s;
        sp_mi_r <= sat_mi;
        sp_h_r  <= sat_h;
        dv_r    <= in_day_val;
      end
      ccdst_pkg::CMD_STEP: begin
        day_w_r <= is_rew ? r_day : a_day;
      end
      ccdst_pkg::CMD_WALK: begin
        if (!walk_done) begin
          day_w_r <= is_rew ? 12'(day_w_r + {7'd0, wk_len})
                            : 12'(day_w_r - {7'd0, wk_len});
        end
      end
      ccdst_pkg::CMD_MULY, ccdst_pkg::CMD_MULW: begin
        mq_r <= prod100[26:19];
      end
      ccdst_pkg::CMD_WPREP: begin
        if (month_r < 4'd2) begin
          wy_r <= {1'b0, year_r} + 15'd399;
          wd_r <= {1'b0, year_r} + {10'd0, day_r} + {10'd0, ccdst_pkg::month_term(month_r)}
                  + 15'd411;
        end else begin
          wy_r <= {1'b0, year_r} + 15'd400;
          wd_r <= {1'b0, year_r} + {10'd0, day_r} + {10'd0, ccdst_pkg::month_term(month_r)}
                  + 15'd409;
        end
      end
      ccdst_pkg::CMD_WSUM: begin
        ws_r <= wd_r + {2'd0, wy_r[14:2]} - {7'd0, mq_r} + {9'd0, mq_r[7:2]};
      end
      ccdst_pkg::CMD_MUL7: begin
        q7_r <= prod7[29:18];
      end
      ccdst_pkg::CMD_FINISH: begin
        out_year_out    <= year_r;
        out_month_out   <= month_r;
        out_day_out     <= day_r;
        out_hour_out    <= hour_r;
        out_minute_out  <= min_r;
        out_second_out  <= sec_r;
        out_msec_out    <= msec_r;
        out_weekday_out <= wday;
        out_dst_event   <= fire_spring ? ccdst_pkg::DST_SPRING
                         : fire_fall   ? ccdst_pkg::DST_FALL
                         : ccdst_pkg::DST_NONE;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/core/calendar_clock_with_dst.sv
// An advance or rewind item steps the time fields, then walks k month boundaries (one month
// per cycle, up to about 35); a load passes LQ, LMOD and LDAY, an unknown mode skips ahead;
// WY, WQ, WSUM and WQ7 then find the weekday and WOUT registers the result once the last is
// taken. The next item can be taken in the cycle after that, and the result register lets it
// in while the last result waits. Reset (synchronous, rst_n low) sets 2014-01-01 00:00.
module calendar_clock_with_dst (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [9:0]  in_msec_val,
  input  logic [5:0]  in_sec_val,
  input  logic [5:0]  in_min_val,
  input  logic [4:0]  in_hour_val,
  input  logic [9:0]  in_day_val,
  input  logic [3:0]  in_month_val,
  input  logic [13:0] in_year_val,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_year_out,
  output logic [3:0]  out_month_out,
  output logic [4:0]  out_day_out,
  output logic [4:0]  out_hour_out,
  output logic [5:0]  out_minute_out,
  output logic [5:0]  out_second_out,
  output logic [9:0]  out_msec_out,
  output logic [2:0]  out_weekday_out,
  output logic [1:0]  out_dst_event
);

  ccdst_pkg::cmd_t cmd;
  logic            walk_done;

  ccdst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .walk_done (walk_done),
    .cmd       (cmd)
  );

  ccdst_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mode         (in_mode),
    .in_msec_val     (in_msec_val),
    .in_sec_val      (in_sec_val),
    .in_min_val      (in_min_val),
    .in_hour_val     (in_hour_val),
    .in_day_val      (in_day_val),
    .in_month_val    (in_month_val),
    .in_year_val     (in_year_val),
    .walk_done       (walk_done),
    .out_year_out    (out_year_out),
    .out_month_out   (out_month_out),
    .out_day_out     (out_day_out),
    .out_hour_out    (out_hour_out),
    .out_minute_out  (out_minute_out),
    .out_second_out  (out_second_out),
    .out_msec_out    (out_msec_out),
    .out_weekday_out (out_weekday_out),
    .out_dst_event   (out_dst_event)
  );

`ifndef SYNTHESIS
  a_take_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> cmd == ccdst_pkg::CMD_TAKE)
    else $error("accepted item without capture command");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in progress");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_month_out <= 4'd11 && out_weekday_out <= 3'd6 && out_day_out <= 5'd30)
    else $error("result field out of range");

  a_dst_sunday: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dst_event != ccdst_pkg::DST_NONE |->
      out_weekday_out == ccdst_pkg::SUNDAY && out_day_out >= 5'd24 && out_hour_out >= 5'd2)
    else $error("daylight saving event outside a qualifying Sunday");
`endif

endmodule

FILE: tb/calendar_clock_with_dst_test.sv
module calendar_clock_with_dst_test;

  typedef struct {
    ccdst_pkg::mode_t mode;
    logic [9:0]  msec;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [9:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } request_t;

  typedef struct {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  msec;
    logic [2:0]  weekday;
    logic [1:0]  dst;
  } reading_t;

  localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int YEAR_SPAN = 16384;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_mode;
  logic [9:0]  in_msec_val;
  logic [5:0]  in_sec_val;
  logic [5:0]  in_min_val;
  logic [4:0]  in_hour_val;
  logic [9:0]  in_day_val;
  logic [3:0]  in_month_val;
  logic [13:0] in_year_val;
  logic        out_valid;
  logic        out_ready;
  logic [13:0] out_year_out;
  logic [3:0]  out_month_out;
  logic [4:0]  out_day_out;
  logic [4:0]  out_hour_out;
  logic [5:0]  out_minute_out;
  logic [5:0]  out_second_out;
  logic [9:0]  out_msec_out;
  logic [2:0]  out_weekday_out;
  logic [1:0]  out_dst_event;

  int cal_year, cal_month, cal_day, cal_hour, cal_min, cal_sec, cal_msec;
  bit summer_latched, winter_latched;

  reading_t pending_readings[$];
  int       mismatches;
  bit       sender_idle_on;
  bit       receiver_stall_on;
  int       long_hold_cycles;
  int       stall_left;

  calendar_clock_with_dst dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_msec_val    (in_msec_val),
    .in_sec_val     (in_sec_val),
    .in_min_val     (in_min_val),
    .in_hour_val    (in_hour_val),
    .in_day_val     (in_day_val),
    .in_month_val   (in_month_val),
    .in_year_val    (in_year_val),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_year_out   (out_year_out),
    .out_month_out  (out_month_out),
    .out_day_out    (out_day_out),
    .out_hour_out   (out_hour_out),
    .out_minute_out (out_minute_out),
    .out_second_out (out_second_out),
    .out_msec_out   (out_msec_out),
    .out_weekday_out(out_weekday_out),
    .out_dst_event  (out_dst_event)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("FAIL calendar_clock_with_dst");
    $finish;
  end

  function automatic int month_days(input int m, input int y);
    int n;
    n = MONTH_LEN[m % 12];
    if (m == int'(ccdst_pkg::MONTH_FEB) && y % 4 == 0 && (y % 100 != 0 || y % 400 == 0)) begin
      n++;
    end
    return n;
  endfunction

  function automatic int weekday_now();
    int d, m, y;
    d = cal_day + 1;
    m = cal_month + 1;
    y = cal_year + 400;
    if (m < 3) begin
      d += y;
      y -= 1;
    end else begin
      d += y - 2;
    end
    return (23 * m / 9 + d + 4 + y / 4 - y / 100 + y / 400 + 6) % 7;
  endfunction

  function automatic int clip(input int v, input int hi);
    return (v > hi) ? hi : v;
  endfunction

  function automatic reading_t predict_reading(input request_t rq);
    int ms, s, mi, h, dv, day, month, year, maxd, v, borrow, wd;
    reading_t r;
    ms = clip(int'(rq.msec), int'(ccdst_pkg::MSEC_MAX));
    s  = clip(int'(rq.sec), int'(ccdst_pkg::SEC_MAX));
    mi = clip(int'(rq.min), int'(ccdst_pkg::MIN_MAX));
    h  = clip(int'(rq.hour), int'(ccdst_pkg::HOUR_MAX));
    dv = int'(rq.day);
    month = cal_month;
    year  = cal_year;
    case (rq.mode)
      ccdst_pkg::MODE_ADV: begin
        cal_msec += ms;
        if (cal_msec >= 1000) begin cal_sec++; cal_msec -= 1000; end
        cal_sec += s;
        if (cal_sec >= 60) begin cal_min++; cal_sec -= 60; end
        cal_min += mi;
        if (cal_min >= 60) begin cal_hour++; cal_min -= 60; end
        cal_hour += h;
        day = cal_day;
        if (cal_hour >= 24) begin day++; cal_hour -= 24; end
        day += dv;
        maxd = month_days(month, year);
        while (day >= maxd) begin
          day -= maxd;
          month++;
          if (month >= 12) begin
            month -= 12;
            year = (year + 1) % YEAR_SPAN;
          end
          maxd = month_days(month, year);
        end
        cal_day = day;
        cal_month = month;
        cal_year = year;
      end
      ccdst_pkg::MODE_REW: begin
        v = cal_msec - ms;
        borrow = 0;
        if (v < 0) begin borrow = 1; v += 1000; end
        cal_msec = v;
        v = cal_sec - borrow - s;
        borrow = 0;
        if (v < 0) begin borrow = 1; v += 60; end
        cal_sec = v;
        v = cal_min - borrow - mi;
        borrow = 0;
        if (v < 0) begin borrow = 1; v += 60; end
        cal_min = v;
        v = cal_hour - borrow - h;
        borrow = 0;
        if (v < 0) begin borrow = 1; v += 24; end
        cal_hour = v;
        day = cal_day - borrow - dv;
        while (day < 0) begin
          month--;
          if (month < 0) begin
            month += 12;
            year = (year + YEAR_SPAN - 1) % YEAR_SPAN;
          end
          day += month_days(month, year);
        end
        cal_day = day;
        cal_month = month;
        cal_year = year;
      end
      ccdst_pkg::MODE_LOAD: begin
        cal_year  = int'(rq.year);
        cal_month = clip(int'(rq.month), int'(ccdst_pkg::MONTH_MAX));
        cal_day   = clip(dv, month_days(cal_month, cal_year) - 1);
        cal_hour  = h;
        cal_min   = mi;
        cal_sec   = s;
        cal_msec  = ms;
      end
      default: begin
      end
    endcase

    wd = weekday_now();
    r.dst = ccdst_pkg::DST_NONE;
    if (cal_day >= int'(ccdst_pkg::DST_DAY_MIN) && cal_hour >= int'(ccdst_pkg::DST_HOUR_MIN)
        && wd == int'(ccdst_pkg::SUNDAY)) begin
      if (cal_month == int'(ccdst_pkg::MONTH_MAR) && !summer_latched) begin
        summer_latched = 1'b1;
        winter_latched = 1'b0;
        r.dst = ccdst_pkg::DST_SPRING;
      end else if (cal_month == int'(ccdst_pkg::MONTH_OCT) && !winter_latched) begin
        winter_latched = 1'b1;
        summer_latched = 1'b0;
        r.dst = ccdst_pkg::DST_FALL;
      end
    end
    r.year    = 14'(cal_year);
    r.month   = 4'(cal_month);
    r.day     = 5'(cal_day);
    r.hour    = 5'(cal_hour);
    r.minute  = 6'(cal_min);
    r.second  = 6'(cal_sec);
    r.msec    = 10'(cal_msec);
    r.weekday = 3'(wd);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      flag_error($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readings.size() == 0) begin
        flag_error("result with no item outstanding");
      end else begin
        want = pending_readings.pop_front();
        check_field("year", int'(out_year_out), int'(want.year));
        check_field("month", int'(out_month_out), int'(want.month));
        check_field("day", int'(out_day_out), int'(want.day));
        check_field("hour", int'(out_hour_out), int'(want.hour));
        check_field("minute", int'(out_minute_out), int'(want.minute));
        check_field("second", int'(out_second_out), int'(want.second));
        check_field("msec", int'(out_msec_out), int'(want.msec));
        check_field("weekday", int'(out_weekday_out), int'(want.weekday));
        check_field("dst_event", int'(out_dst_event), int'(want.dst));
      end
    end
  end

  // receiver: random stall bursts, plus a long hold on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_cycles > 0) begin
        out_ready <= 1'b0;
        long_hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (receiver_stall_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 9);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic request_t load_at(input int yr, input int mo, input int dy, input int h,
                                       input int mi, input int s, input int ms);
    request_t rq;
    rq.mode  = ccdst_pkg::MODE_LOAD;
    rq.year  = 14'(yr);
    rq.month = 4'(mo);
    rq.day   = 10'(dy);
    rq.hour  = 5'(h);
    rq.min   = 6'(mi);
    rq.sec   = 6'(s);
    rq.msec  = 10'(ms);
    return rq;
  endfunction

  function automatic request_t span_of(input ccdst_pkg::mode_t m, input int dy, input int h,
                                       input int mi, input int s, input int ms);
    request_t rq;
    rq.mode  = m;
    rq.day   = 10'(dy);
    rq.hour  = 5'(h);
    rq.min   = 6'(mi);
    rq.sec   = 6'(s);
    rq.msec  = 10'(ms);
    rq.month = 4'($urandom_range(0, 15));
    rq.year  = 14'($urandom_range(0, 16383));
    return rq;
  endfunction

  task automatic send_item(input request_t rq);
    if (sender_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= rq.mode;
    in_msec_val  <= rq.msec;
    in_sec_val   <= rq.sec;
    in_min_val   <= rq.min;
    in_hour_val  <= rq.hour;
    in_day_val   <= rq.day;
    in_month_val <= rq.month;
    in_year_val  <= rq.year;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_readings.push_back(predict_reading(rq));
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  function automatic request_t random_request();
    request_t rq;
    int sel, dy;
    sel = $urandom_range(0, 99);
    dy = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
    if (sel < 35) begin
      rq = span_of(ccdst_pkg::MODE_ADV, dy, $urandom_range(0, 31), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 1023));
    end else if (sel < 65) begin
      rq = span_of(ccdst_pkg::MODE_REW, dy, $urandom_range(0, 31), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 1023));
    end else if (sel < 95) begin
      if ($urandom_range(0, 3) == 0) begin
        rq = load_at($urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 1023),
                     $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63),
                     $urandom_range(0, 1023));
      end else begin
        rq = load_at($urandom_range(1, 9999), $urandom_range(0, 11), $urandom_range(0, 30),
                     $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59),
                     $urandom_range(0, 999));
      end
    end else begin
      rq = span_of(ccdst_pkg::MODE_KEEP, $urandom_range(0, 1023), $urandom_range(0, 31),
                   $urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 1023));
    end
    return rq;
  endfunction

  task automatic test_load_extremes();
    send_item(span_of(ccdst_pkg::MODE_KEEP, 1023, 31, 63, 63, 1023));
    send_item(load_at(9999, 11, 30, 23, 59, 59, 999));
    send_item(span_of(ccdst_pkg::MODE_ADV, 0, 31, 63, 63, 1023));
    send_item(load_at(2000, 15, 1023, 31, 63, 63, 1023));
    send_item(load_at(2000, int'(ccdst_pkg::MONTH_FEB), 1023, 0, 0, 0, 0));
    send_item(load_at(1900, int'(ccdst_pkg::MONTH_FEB), 1023, 0, 0, 0, 0));
    send_item(load_at(2024, int'(ccdst_pkg::MONTH_FEB), 1023, 12, 30, 30, 500));
  endtask

  task automatic test_span_carries();
    send_item(load_at(16383, 11, 30, 23, 59, 59, 999));
    send_item(span_of(ccdst_pkg::MODE_ADV, 0, 0, 0, 0, 1));
    send_item(span_of(ccdst_pkg::MODE_REW, 0, 0, 0, 0, 1));
    send_item(load_at(0, 0, 0, 0, 0, 0, 0));
    send_item(span_of(ccdst_pkg::MODE_REW, 0, 0, 0, 0, 1));
    send_item(load_at(1900, int'(ccdst_pkg::MONTH_FEB), 27, 23, 59, 59, 999));
    send_item(span_of(ccdst_pkg::MODE_ADV, 1023, 23, 59, 59, 999));
    send_item(span_of(ccdst_pkg::MODE_REW, 1023, 31, 63, 63, 1023));
    send_item(load_at(1, 0, 0, 0, 0, 0, 0));
    send_item(span_of(ccdst_pkg::MODE_REW, 1023, 0, 0, 0, 0));
  endtask

  task automatic test_dst_events();
    send_item(load_at(2014, int'(ccdst_pkg::MONTH_MAR), 29, 2, 0, 0, 0));
    send_item(span_of(ccdst_pkg::MODE_KEEP, 0, 0, 0, 0, 0));
    send_item(load_at(2014, int'(ccdst_pkg::MONTH_OCT), 25, 3, 0, 0, 0));
    send_item(load_at(2015, int'(ccdst_pkg::MONTH_MAR), 28, 1, 59, 59, 999));
    send_item(span_of(ccdst_pkg::MODE_ADV, 0, 0, 0, 0, 1));
    send_item(load_at(2015, int'(ccdst_pkg::MONTH_OCT), 24, 2, 0, 0, 0));
    send_item(load_at(2015, int'(ccdst_pkg::MONTH_MAR), 21, 5, 0, 0, 0));
  endtask

  task automatic test_backpressure();
    long_hold_cycles = 300;
    repeat (20) send_item(random_request());
    pause_until_drained();
  endtask

  task automatic test_random_traffic(input int n_items);
    int sent, steps;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 7) == 0) begin
        // late March or October, then step through the small hours
        send_item(load_at($urandom_range(1, 9999),
                          $urandom_range(0, 1) ? int'(ccdst_pkg::MONTH_MAR)
                                               : int'(ccdst_pkg::MONTH_OCT),
                          $urandom_range(22, 30), $urandom_range(0, 2),
                          $urandom_range(0, 59), $urandom_range(0, 59),
                          $urandom_range(0, 999)));
        sent++;
        steps = $urandom_range(2, 5);
        repeat (steps) begin
          send_item(span_of($urandom_range(0, 4) == 0 ? ccdst_pkg::MODE_REW
                                                      : ccdst_pkg::MODE_ADV,
                            $urandom_range(0, 1), $urandom_range(0, 3),
                            $urandom_range(0, 59), $urandom_range(0, 59),
                            $urandom_range(0, 999)));
          sent++;
        end
      end else begin
        send_item(random_request());
        sent++;
      end
    end
  endtask

  initial begin
    int guard;
    mismatches        = 0;
    long_hold_cycles  = 0;
    stall_left        = 0;
    sender_idle_on    = 1'b1;
    receiver_stall_on = 1'b1;
    cal_year  = int'(ccdst_pkg::YEAR_RESET);
    cal_month = 0;
    cal_day   = 0;
    cal_hour  = 0;
    cal_min   = 0;
    cal_sec   = 0;
    cal_msec  = 0;
    summer_latched = 1'b0;
    winter_latched = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_mode      <= ccdst_pkg::MODE_ADV;
    in_msec_val  <= '0;
    in_sec_val   <= '0;
    in_min_val   <= '0;
    in_hour_val  <= '0;
    in_day_val   <= '0;
    in_month_val <= '0;
    in_year_val  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_load_extremes();
    test_span_carries();
    test_dst_events();
    test_backpressure();
    test_random_traffic(880);
    pause_until_drained();
    sender_idle_on    = 1'b0;
    receiver_stall_on = 1'b0;
    test_random_traffic(100);

    in_valid <= 1'b0;
    guard = 0;
    while (pending_readings.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
    if (pending_readings.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_readings.size()));
    end
    if (mismatches == 0) begin
      $display("PASS calendar_clock_with_dst");
    end else begin
      $display("FAIL calendar_clock_with_dst");
    end
    $finish;
  end

endmodule
